// ===== rtl/apr_pkg.sv =====
package apr_pkg;

  localparam int SAMPLES_PER_PACKET = 32;
  localparam int PACKET_SLOTS       = 8;

  // One physical slot more than the ring holds: the packet being gathered
  // always has a slot of its own, so a full ring is never overwritten.
  localparam int PHYS_SLOTS  = PACKET_SLOTS + 1;
  localparam int SLOT_W      = (PHYS_SLOTS > 1) ? $clog2(PHYS_SLOTS) : 1;
  localparam int CNT_W       = $clog2(SAMPLES_PER_PACKET + 1);
  localparam int RAM_DEPTH   = PHYS_SLOTS * SAMPLES_PER_PACKET;
  localparam int ADDR_W      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_TAKE   = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WORD      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_TAKE,
    CMD_CANCEL,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_sample;
    logic [31:0] seq_number;
    logic        last;
  } res_t;

endpackage

// ===== rtl/apr_ram.sv =====
module apr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/apr_front.sv =====
module apr_front
  import apr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_word,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  cmd_t              decoded;
  logic              do_push;

  // Classify the request; keep only the upper half of the sample.
  always_comb begin
    decoded.sample = in_word[31:16];
    unique case (in_func)
      FUNC_PUSH:   decoded.kind = CMD_PUSH;
      FUNC_TAKE:   decoded.kind = CMD_TAKE;
      FUNC_CANCEL: decoded.kind = CMD_CANCEL;
      default:     decoded.kind = CMD_NOP;
    endcase
  end

  assign in_ready  = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push   = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (cmd_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/apr_back.sv =====
module apr_back
  import apr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [CNT_W-1:0] idx);
    slot_addr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(SAMPLES_PER_PACKET) + ADDR_W'(idx));
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    slot_inc = (slot == SLOT_W'(PHYS_SLOTS - 1)) ? '0 : slot + 1'b1;
  endfunction

  logic [CNT_W-1:0]  partial_count;
  logic [31:0]       produced_count;
  logic [31:0]       consumed_count;
  logic              cancel_flag;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic              tk_active;
  logic [CNT_W-1:0]  tk_idx;
  logic              r_valid;
  logic              r_last;
  logic [31:0]       r_seq;
  logic [15:0]       rdata;

  logic              out_free;
  logic              move;
  logic              rd_issue;
  logic              rd_final;
  logic              cmd_start;
  logic              ring_full;
  logic              ring_empty;
  logic [CNT_W-1:0]  cnt_inc;
  logic              push_ok;
  logic              push_done;
  logic              ram_we;
  logic              single_load;
  logic [2:0]        single_status;

  assign out_free   = !out_valid || out_ready;
  assign move       = r_valid && out_free;
  assign rd_issue   = tk_active && (!r_valid || move);
  assign rd_final   = (tk_idx == CNT_W'(SAMPLES_PER_PACKET - 1));
  assign cmd_start  = cmd_valid && !tk_active && !r_valid && out_free;
  assign cmd_pop    = cmd_start;

  assign ring_full  = ((produced_count - consumed_count) >= 32'(PACKET_SLOTS)) ||
                      (produced_count == '1);
  assign ring_empty = (produced_count == consumed_count);
  assign cnt_inc    = partial_count + 1'b1;
  assign push_ok    = (cmd.kind == CMD_PUSH) && !cancel_flag;
  assign push_done  = (cnt_inc == CNT_W'(SAMPLES_PER_PACKET));
  assign ram_we     = cmd_start && push_ok;

  // Every request but a take that finds a packet answers with one result.
  assign single_load = cmd_start &&
                       !((cmd.kind == CMD_TAKE) && !cancel_flag && !ring_empty);

  always_comb begin
    single_status = ST_OK;
    case (cmd.kind)
      CMD_PUSH: begin
        if (cancel_flag) begin
          single_status = ST_CANCELLED;
        end else if (push_done && ring_full) begin
          single_status = ST_OVERFLOW;
        end
      end
      CMD_TAKE: begin
        single_status = cancel_flag ? ST_CANCELLED : ST_EMPTY;
      end
      default: single_status = ST_OK;
    endcase
  end

  apr_ram #(
    .WIDTH(16),
    .DEPTH(RAM_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_addr(wr_slot, partial_count)),
    .wdata(cmd.sample),
    .re   (rd_issue),
    .raddr(slot_addr(rd_slot, tk_idx)),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_count  <= '0;
      produced_count <= '0;
      consumed_count <= '0;
      cancel_flag    <= 1'b0;
      wr_slot        <= '0;
      rd_slot        <= '0;
      tk_active      <= 1'b0;
      tk_idx         <= '0;
      r_valid        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd_start) begin
        case (cmd.kind)
          CMD_PUSH: begin
            if (!cancel_flag) begin
              if (!push_done) begin
                partial_count <= cnt_inc;
              end else if (ring_full) begin
                partial_count <= cnt_inc;
                cancel_flag   <= 1'b1;
              end else begin
                partial_count  <= '0;
                produced_count <= produced_count + 1'b1;
                wr_slot        <= slot_inc(wr_slot);
              end
            end
          end
          CMD_TAKE: begin
            if (!cancel_flag && !ring_empty) begin
              tk_active <= 1'b1;
              tk_idx    <= '0;
            end
          end
          CMD_CANCEL: cancel_flag <= 1'b1;
          default: ;
        endcase
      end

      if (rd_issue) begin
        tk_idx <= tk_idx + 1'b1;
        if (rd_final) begin
          tk_active      <= 1'b0;
          consumed_count <= consumed_count + 1'b1;
          rd_slot        <= slot_inc(rd_slot);
        end
      end

      if (rd_issue) begin
        r_valid <= 1'b1;
      end else if (move) begin
        r_valid <= 1'b0;
      end

      if (move || single_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      r_last <= rd_final;
      r_seq  <= consumed_count;
    end
    if (move) begin
      res.status     <= ST_WORD;
      res.out_sample <= rdata;
      res.seq_number <= r_seq;
      res.last       <= r_last;
    end else if (single_load) begin
      res.status     <= single_status;
      res.out_sample <= '0;
      res.seq_number <= '0;
      res.last       <= 1'b1;
    end
  end

endmodule

// ===== rtl/audio_packet_ring_fifo.sv =====
// Audio packet ring FIFO.
// Requests enter on the s_ stream: s_tuser selects push (0), take (1) or
// cancel (2); s_tdata carries the left-aligned 32-bit sample for a push.
// Results leave on the m_ stream: m_tuser is the status, m_tdata the packet
// word and the sequence number, m_tlast marks the final result of a request.
// A front stage decodes requests into a two-entry command queue; the back
// stage executes one command at a time against the slot RAM.
// A request waits in the command queue until the back is free; a push or
// cancel result is presented in the cycle after the back starts it. A take
// that finds a packet passes through start, RAM read and output register to
// its first word, then one word per cycle while m_tready is high, for
// SAMPLES_PER_PACKET words. Throughput: one push per cycle while m_tready
// is high; a take holds the back through its reads on the RAM's one read port.
// Packets are written in place into a slot of their own, so completing a
// packet costs no copy.
// Reset clears the counters, the cancel flag and both streams' control; the
// slot RAM is not cleared and is only read where a completed push wrote.
// When m_tready is low, hold the current result; the queue keeps taking
// requests until it fills, then s_tready drops.
module audio_packet_ring_fifo
  import apr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_word
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] out_sample, [47:16] seq_number
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast    // last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  // Front: decode each request and queue it.
  apr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser),
    .in_word  (s_tdata),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  // Back: advance the ring state and stream out the results.
  apr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {res.seq_number, res.out_sample};
  assign m_tuser = res.status;
  assign m_tlast = res.last;

  // A result that carries no packet word is the only result of its request.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_WORD)) |-> m_tlast)
    else $error("single result without last mark");

  // Drop payload to zero on results that carry no packet word.
  a_single_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_WORD)) |-> (m_tdata == '0))
    else $error("nonzero payload on status-only result");

  // Packet words stream without gaps once the receiver takes them.
  a_word_burst: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && (m_tuser == ST_WORD) && !m_tlast)
      |=> (m_tvalid && (m_tuser == ST_WORD)))
    else $error("gap inside packet burst");

endmodule
